// ===== hw/rtl/acw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sliding complex chi-square block.
// Holds sizes, state encoding, register indexes and the controller command struct.
package acw_pkg;

  localparam int Channels = 16;
  localparam int MaxTaps  = 64;
  localparam int ChW      = 4;
  localparam int TapW     = 6;
  localparam int AddrW    = ChW + TapW;
  localparam int Depth    = Channels * MaxTaps;
  localparam int LenW     = 7;
  localparam int NumW     = 56;
  localparam int DenW     = 40;

  localparam logic [LenW-1:0] RegWindowLength    = 7'd0;
  localparam logic [LenW-1:0] RegReferenceOffset = 7'd1;
  localparam logic            OpSample           = 1'b0;
  localparam logic            OpLoad             = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REF,
    ST_REFWAIT,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } acw_state_t;

  typedef struct packed {
    logic            clear;      // reset accumulators
    logic            ref_load;   // capture history read data as reference
    logic            mac_en;     // accumulate one tap from read data
    logic            div_start;  // begin division
    logic            div_step;   // one quotient bit
  } acw_cmd_t;

  typedef struct packed {
    logic div_done;
  } acw_stat_t;

endpackage

// ===== hw/rtl/acw_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and output words.
// Depends on acw_pkg for field widths.
interface acw_in_if import acw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [ChW-1:0]        channel;
  logic [TapW-1:0]       tap;
  logic signed [15:0]    real_part;
  logic signed [15:0]    imag_part;
  logic                  restart;
  modport source (output valid, operation, channel, tap, real_part, imag_part, restart,
                  input ready);
  modport sink (input valid, operation, channel, tap, real_part, imag_part, restart,
                output ready);
endinterface

interface acw_out_if import acw_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] out_channel;
  logic [31:0]    chisq;
  modport source (output valid, out_channel, chisq, input ready);
  modport sink (input valid, out_channel, chisq, output ready);
endinterface

// ===== hw/rtl/acw_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module acw_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/acw_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: complex multiply, rounded squares, accumulators and restoring divider.
// Depends on acw_pkg for the command struct and widths.
module acw_datapath import acw_pkg::*; (
  input  logic            clk,
  input  acw_cmd_t        cmd,
  output acw_stat_t       stat,
  input  logic [31:0]     coef_word,
  input  logic [31:0]     hist_word,
  input  logic [LenW-1:0] len,
  output logic [31:0]     quotient
);
  logic signed [15:0] rr, ri;
  logic signed [15:0] ar, ai, xr, xi;
  logic signed [32:0] pr0, pr1, pi0, pi1;
  logic signed [33:0] dr, di;
  logic [33:0]        mr, mi;
  logic [26:0]        qr, qi;
  logic [NumW-1:0]    num;
  logic [DenW-1:0]    asum;
  logic [NumW-1:0]    rem;
  logic [DenW:0]      den;
  logic [31:0]        q;
  logic               sat;
  logic [5:0]         bitcnt;
  logic [DenW:0]      den_next;

  assign ar = coef_word[31:16];
  assign ai = coef_word[15:0];
  assign xr = hist_word[31:16];
  assign xi = hist_word[15:0];

  // stage 1: register products
  always_ff @(posedge clk) begin
    if (cmd.ref_load) begin
      rr <= hist_word[31:16];
      ri <= hist_word[15:0];
    end
    pr0 <= 33'(ar * rr);
    pr1 <= 33'(ai * ri);
    pi0 <= 33'(ar * ri);
    pi1 <= 33'(ai * rr);
  end

  logic signed [15:0] xr_d, xi_d;
  logic [31:0]        amag;
  logic               mac_d;
  always_ff @(posedge clk) begin
    xr_d  <= xr;
    xi_d  <= xi;
    amag  <= 32'(ar * ar) + 32'(ai * ai);
    mac_d <= cmd.mac_en;
  end

  always_comb begin
    dr = 34'(pr0) - 34'(pr1) - (34'(xr_d) <<< 15);
    di = 34'(pi0) + 34'(pi1) - (34'(xi_d) <<< 15);
    mr = dr[33] ? 34'(-dr) : 34'(dr);
    mi = di[33] ? 34'(-di) : 34'(di);
    qr = 27'((mr + 34'd64) >> 7);
    qi = 27'((mi + 34'd64) >> 7);
  end

  logic [26:0] qr_d, qi_d;
  logic        mac_dd;
  logic [31:0] amag_d;
  always_ff @(posedge clk) begin
    qr_d   <= qr;
    qi_d   <= qi;
    mac_dd <= mac_d;
    amag_d <= amag;
  end

  logic [53:0] sq_r, sq_i;
  logic [31:0] amag_dd;
  logic        mac_ddd;
  always_ff @(posedge clk) begin
    sq_r    <= 54'(qr_d) * 54'(qr_d);
    sq_i    <= 54'(qi_d) * 54'(qi_d);
    amag_dd <= amag_d;
    mac_ddd <= mac_dd;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      num  <= '0;
      asum <= '0;
    end else if (mac_ddd) begin
      num  <= num + NumW'(sq_r) + NumW'(sq_i);
      asum <= asum + DenW'(amag_dd);
    end
  end

  // restoring division: quotient bits 55 down to 0; bits above 31 saturate
  assign den_next = (DenW+1)'({len, 31'd0}) - (DenW+1)'(asum);

  logic [NumW-1:0] dividend;
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      den      <= den_next;
      rem      <= '0;
      dividend <= num;
      q        <= '0;
      sat      <= (den_next == '0);
      bitcnt   <= 6'(NumW);
    end else if (cmd.div_step && bitcnt != 0) begin
      if ({rem[NumW-2:0], dividend[NumW-1]} >= NumW'(den)) begin
        rem <= {rem[NumW-2:0], dividend[NumW-1]} - NumW'(den);
        q   <= {q[30:0], 1'b1};
        if (q[31]) sat <= 1'b1;
      end else begin
        rem <= {rem[NumW-2:0], dividend[NumW-1]};
        q   <= {q[30:0], 1'b0};
        if (q[31]) sat <= 1'b1;
      end
      dividend <= {dividend[NumW-2:0], 1'b0};
      bitcnt   <= bitcnt - 6'd1;
    end
  end

  assign stat.div_done = (bitcnt == 0);
  assign quotient      = sat ? 32'hFFFF_FFFF : q;
endmodule

// ===== hw/rtl/acw_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: accepts words, updates fill state, sequences tap walk and division.
// Depends on acw_pkg.
module acw_ctrl import acw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [LenW-1:0]        cfg_index,
  input  logic [LenW-1:0]        cfg_data,
  acw_in_if.sink                 in_ch,
  acw_out_if.source              out_ch,
  output acw_cmd_t               cmd,
  input  acw_stat_t              stat,
  input  logic [31:0]            quotient,
  output logic                   coef_we,
  output logic [AddrW-1:0]       coef_addr,
  output logic                   hist_we,
  output logic [AddrW-1:0]       hist_addr,
  output logic [31:0]            wdata,
  output logic [LenW-1:0]        len_eff
);
  acw_state_t        state, state_next;
  logic [LenW-1:0]   window_length;
  logic [LenW-1:0]   reference_offset;
  logic [TapW-1:0]   wpos [Channels];
  logic [LenW-1:0]   fill [Channels];
  logic [ChW-1:0]    cur_ch;
  logic [TapW-1:0]   base_pos;   // position of window oldest sample
  logic [LenW-1:0]   cnt;
  logic [2:0]        drain;
  logic [LenW-1:0]   ref_pos;
  logic signed [LenW:0] lat;
  logic              accept;
  logic [LenW-1:0]   fill_new;
  logic [TapW-1:0]   wp_new;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    len_eff = window_length;
    if (window_length == '0) len_eff = 7'd1;
    if (window_length > 7'(MaxTaps)) len_eff = 7'(MaxTaps);
    lat = (LenW+1)'(signed'(reference_offset));
    if (lat > 0) lat = '0;
    if (lat < -signed'((LenW+1)'(len_eff - 7'd1))) lat = -signed'((LenW+1)'(len_eff - 7'd1));
    ref_pos = 7'((LenW+1)'(len_eff - 7'd1) + lat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= 7'd64;
      reference_offset <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegWindowLength) window_length <= cfg_data;
      else if (cfg_index == RegReferenceOffset) reference_offset <= cfg_data;
    end
  end

  assign wp_new   = wpos[in_ch.channel] + TapW'(1);
  assign fill_new = (in_ch.restart ? 7'd0 : fill[in_ch.channel]) +
                    ((in_ch.restart || fill[in_ch.channel] < 7'(MaxTaps)) ? 7'd1 : 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < Channels; c++) begin
        wpos[c] <= '0;
        fill[c] <= '0;
      end
    end else if (accept && in_ch.operation == OpSample) begin
      wpos[in_ch.channel] <= wp_new;
      for (int c = 0; c < Channels; c++) begin
        if (ChW'(c) == in_ch.channel) fill[c] <= fill_new;
        else if (in_ch.restart) fill[c] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_ch   <= in_ch.channel;
        base_pos <= wp_new - TapW'(len_eff);
        cnt      <= '0;
        drain    <= '0;
      end
      ST_MAC: begin
        if (cnt != len_eff) cnt <= cnt + 7'd1;
        else drain <= drain + 3'd1;
      end
      default: ;
    endcase
  end

  logic out_valid;
  logic [31:0] out_q;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_OUT && !out_valid) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
    if (state == ST_OUT && !out_valid) out_q <= quotient;
  end
  assign out_ch.valid       = out_valid;
  assign out_ch.out_channel = cur_ch;
  assign out_ch.chisq       = out_q;

  always_comb begin
    state_next = state;
    cmd        = '0;
    coef_we    = 1'b0;
    hist_we    = 1'b0;
    wdata      = {in_ch.real_part, in_ch.imag_part};
    coef_addr  = {cur_ch, TapW'(cnt)};
    hist_addr  = {cur_ch, base_pos + TapW'(cnt)};
    case (state)
      ST_IDLE: begin
        coef_addr = {in_ch.channel, in_ch.tap};
        hist_addr = {in_ch.channel, wpos[in_ch.channel]};
        if (accept) begin
          if (in_ch.operation == OpLoad) coef_we = 1'b1;
          else begin
            hist_we = 1'b1;
            if (fill_new >= len_eff) state_next = ST_REF;
          end
        end
      end
      ST_REF: begin
        hist_addr  = {cur_ch, base_pos + TapW'(ref_pos)};
        state_next = ST_REFWAIT;
      end
      ST_REFWAIT: begin
        cmd.ref_load = 1'b1;
        cmd.clear    = 1'b1;
        state_next   = ST_MAC;
      end
      ST_MAC: begin
        // read data of tap cnt-1 arrives now
        cmd.mac_en = (cnt != '0) && (drain == '0);
        if (drain == 3'd4) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_valid && out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE) else $error("ready outside idle");
  ap_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_OUT) else $error("result outside output state");
  ap_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill[cur_ch] <= 7'(MaxTaps)) else $error("fill overflow");
endmodule

// ===== hw/rtl/autocorrelation_chisq_window_top.sv =====
`timescale 1ns / 1ps
// Top level of the sliding complex chi-square block.
// Depends on acw_pkg, acw_if, acw_ram, acw_ctrl, acw_datapath.
//
// Usage:
//   in_ch carries one word per item: a coefficient load (operation=1) writes
//   one complex tap of a channel's row; a sample (operation=0) writes the
//   channel's history and, once the channel holds len_eff samples
//   (window_length clamped to 1..64), produces one word on out_ch with the
//   Q16.16 chi-square. A sample that completes a window runs these steps:
//   one reference read, a wait state, tap reads and MAC pipeline drain,
//   the 56-step restoring divider (one quotient bit per cycle), and the
//   register that holds the result word. Loads and samples with a partial
//   window are taken and leave the block idle.
//   One item is in work at a time; ready is high only while idle.
//   Reset clears fill counts, write positions and config (L=64, offset 0).
//   Stores hold garbage until written; no clearing pass is run.
//   When the receiver stalls, the result word holds and no input is taken.
//   cfg_we/cfg_index/cfg_data write registers 0 (length) and 1 (offset).
module autocorrelation_chisq_window_top import acw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [LenW-1:0] cfg_index,
  input  logic [LenW-1:0] cfg_data,
  acw_in_if.sink          in_ch,
  acw_out_if.source       out_ch
);
  acw_cmd_t         cmd;
  acw_stat_t        stat;
  logic             coef_we, hist_we;
  logic [AddrW-1:0] coef_addr, hist_addr;
  logic [31:0]      wdata, coef_word, hist_word, quotient;
  logic [LenW-1:0]  len_eff;

  acw_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_ch, .out_ch,
    .cmd, .stat, .quotient, .coef_we, .coef_addr, .hist_we, .hist_addr,
    .wdata, .len_eff
  );

  acw_ram #(.Width(32), .Depth(Depth)) u_coef (
    .clk, .we(coef_we), .addr(coef_addr), .wdata, .rdata(coef_word)
  );

  acw_ram #(.Width(32), .Depth(Depth)) u_hist (
    .clk, .we(hist_we), .addr(hist_addr), .wdata, .rdata(hist_word)
  );

  acw_datapath u_dp (
    .clk, .cmd, .stat, .coef_word, .hist_word, .len(len_eff), .quotient
  );
endmodule
